### design/qmr_pkg.sv
// Shared types, constants and helpers for the quantized multiply-requantize block.
package qmr_pkg;

    localparam int unsigned ByteW    = 8;
    localparam int unsigned DiffW    = 9;   // zero-point difference, -255..255
    localparam int unsigned ProdW    = 17;  // product of differences, |d| <= 65025
    localparam int unsigned MultW    = 31;
    localparam int unsigned ShiftW   = 6;
    localparam int unsigned ScaledW  = 48;  // |d * mult| < 2^47
    localparam int unsigned WideW    = 64;  // fraction compare width
    localparam int unsigned ClampW   = 11;  // floored value clamped to -1024..1023
    localparam int unsigned SumW     = 12;
    localparam int unsigned CfgIdxW  = 3;
    localparam int unsigned CfgDataW = 31;

    localparam logic [MultW-1:0]  ScaleMultReset  = 31'd1073741824;
    localparam logic [ShiftW-1:0] ScaleShiftReset = 6'd30;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_SIGNED_MODE  = 3'd0,
        CFG_A_ZERO_POINT = 3'd1,
        CFG_B_ZERO_POINT = 3'd2,
        CFG_Y_ZERO_POINT = 3'd3,
        CFG_SCALE_MULT   = 3'd4,
        CFG_SCALE_SHIFT  = 3'd5
    } cfg_index_t;

    typedef logic signed [DiffW-1:0]   diff_t;
    typedef logic signed [ProdW-1:0]   prod_t;
    typedef logic signed [ScaledW-1:0] scaled_t;

    typedef struct packed {
        logic               signed_mode;
        logic [ByteW-1:0]   a_zero_point;
        logic [ByteW-1:0]   b_zero_point;
        logic [ByteW-1:0]   y_zero_point;
        logic [MultW-1:0]   scale_mult;
        logic [ShiftW-1:0]  scale_shift;
    } cfg_t;

    // Raw byte read as unsigned 0..255 or two's complement -128..127.
    function automatic diff_t byte_value(input logic [ByteW-1:0] raw, input logic signed_mode);
        byte_value = signed_mode ? {raw[ByteW-1], raw} : {1'b0, raw};
    endfunction

endpackage

### design/qmr_diff.sv
// Zero-point subtraction stage followed by the operand product stage.
module qmr_diff (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  qmr_pkg::cfg_t         cfg,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [7:0]            a_value,
    input  logic [7:0]            b_value,
    output logic                  out_valid,
    input  logic                  out_ready,
    output qmr_pkg::prod_t        out_prod
);

    logic                 v1_reg;
    qmr_pkg::diff_t       da_reg, db_reg;
    logic                 v2_reg;
    qmr_pkg::prod_t       prod_reg;
    logic                 r1, r2;
    logic signed [9:0]    da_next, db_next;
    logic signed [17:0]   prod_full;

    assign r2       = !v2_reg || out_ready;
    assign r1       = !v1_reg || r2;
    assign in_ready = r1;

    assign da_next = 10'(qmr_pkg::byte_value(a_value, cfg.signed_mode))
                   - 10'(qmr_pkg::byte_value(cfg.a_zero_point, cfg.signed_mode));
    assign db_next = 10'(qmr_pkg::byte_value(b_value, cfg.signed_mode))
                   - 10'(qmr_pkg::byte_value(cfg.b_zero_point, cfg.signed_mode));
    assign prod_full = 18'(da_reg) * 18'(db_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (r1) begin
                v1_reg <= in_valid;
            end
            if (r2) begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (r1 && in_valid) begin
            da_reg <= da_next[8:0];
            db_reg <= db_next[8:0];
        end
        if (r2 && v1_reg) begin
            prod_reg <= prod_full[16:0];
        end
    end

    assign out_valid = v2_reg;
    assign out_prod  = prod_reg;

endmodule

### design/qmr_scale.sv
// Multiplies the operand product by the fixed-point scale mantissa.
module qmr_scale (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  qmr_pkg::cfg_t         cfg,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  qmr_pkg::prod_t        in_prod,
    output logic                  out_valid,
    input  logic                  out_ready,
    output qmr_pkg::scaled_t      out_scaled
);

    logic                 v_reg;
    qmr_pkg::scaled_t     scaled_reg;
    logic signed [48:0]   scaled_full;

    assign in_ready    = !v_reg || out_ready;
    assign scaled_full = 49'(in_prod) * 49'($signed({1'b0, cfg.scale_mult}));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (in_ready) begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            scaled_reg <= scaled_full[47:0];
        end
    end

    assign out_valid  = v_reg;
    assign out_scaled = scaled_reg;

endmodule

### design/qmr_round.sv
// Shift with round-half-even, then zero-point add and saturation into the output register.
module qmr_round (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  qmr_pkg::cfg_t         cfg,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  qmr_pkg::scaled_t      in_scaled,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [7:0]            out_value
);

    logic                 v4_reg;
    qmr_pkg::scaled_t     floor_reg;
    logic                 rnd_reg;
    logic                 v5_reg;
    logic [7:0]           value_reg;
    logic                 r4, r5;

    qmr_pkg::diff_t       yzp;
    qmr_pkg::scaled_t     floor_next;
    logic [63:0]          p_wide, mask, frac, half;
    logic                 rnd_next;

    logic signed [10:0]   fl_clamped;
    logic signed [11:0]   total;
    logic signed [11:0]   lo, hi;
    logic signed [11:0]   sat;

    assign r5       = !v5_reg || out_ready;
    assign r4       = !v4_reg || r5;
    assign in_ready = r4;

    assign yzp = qmr_pkg::byte_value(cfg.y_zero_point, cfg.signed_mode);

    // Arithmetic shift gives the floor; the dropped bits of the sign-extended
    // value decide rounding, ties going to the even sum.
    always_comb begin
        floor_next = in_scaled >>> cfg.scale_shift;
        p_wide     = 64'(in_scaled);
        mask       = (64'd1 << cfg.scale_shift) - 64'd1;
        frac       = p_wide & mask;
        half       = 64'd1 << (cfg.scale_shift - 6'd1);
        rnd_next   = (cfg.scale_shift != '0)
                   && ((frac > half) || ((frac == half) && (floor_next[0] ^ yzp[0])));
    end

    always_comb begin
        if (floor_reg > 48'sd1023) begin
            fl_clamped = 11'sd1023;
        end else if (floor_reg < -48'sd1024) begin
            fl_clamped = -11'sd1024;
        end else begin
            fl_clamped = floor_reg[10:0];
        end
        total = 12'(fl_clamped) + 12'(yzp) + $signed({11'd0, rnd_reg});
        lo    = cfg.signed_mode ? -12'sd128 : 12'sd0;
        hi    = cfg.signed_mode ? 12'sd127 : 12'sd255;
        if (total < lo) begin
            sat = lo;
        end else if (total > hi) begin
            sat = hi;
        end else begin
            sat = total;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            if (r4) begin
                v4_reg <= in_valid;
            end
            if (r5) begin
                v5_reg <= v4_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (r4 && in_valid) begin
            floor_reg <= floor_next;
            rnd_reg   <= rnd_next;
        end
        if (r5 && v4_reg) begin
            value_reg <= sat[7:0];
        end
    end

    assign out_valid = v5_reg;
    assign out_value = value_reg;

endmodule

### design/quantized_multiply_requantize.sv
// Top level of the quantized multiply-requantize block: configuration registers and stage wiring.
//
// Usage: each word on the s_ channel carries one operand pair (a_value in s_tdata[7:0],
// b_value in s_tdata[15:8]). The block subtracts the operand zero points, multiplies
// the differences, scales by scale_mult * 2^-scale_shift with round-half-even, adds
// the output zero point and saturates to the byte range of the selected mode. One
// result word leaves on the m_ channel (y_value in m_tdata[7:0]) for every input word.
// The datapath is a five-stage pipeline: zero-point subtract, operand product, scale
// multiply, shift and round, then zero-point add and saturation into the output
// register. An accepted word moves through the stage registers in this order, and
// m_tvalid rises when it reaches the output register; one word is taken every cycle
// while m_tready stays high.
// When the receiver stalls, each stage holds its word, and the pipeline keeps taking
// input until every stage is full, so bubbles are squeezed out and nothing is lost.
// Reset (aresetn low, synchronous) empties the pipeline and loads the registers with
// a unity scale and zero zero points in unsigned mode. The configuration channel is
// always ready; write it only while no word is in flight. Unknown indexes are ignored.
module quantized_multiply_requantize (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [30:0] cfg_data,
    // Input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] a_value, [15:8] b_value
    // Result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // [7:0] y_value
);

    qmr_pkg::cfg_t     cfg_reg;
    qmr_pkg::cfg_t     cfg_next;

    logic              diff_valid, diff_ready;
    qmr_pkg::prod_t    diff_prod;
    logic              scale_valid, scale_ready;
    qmr_pkg::scaled_t  scale_value;

    assign cfg_ready = 1'b1;

    // Only the low bits of the data bus that fit the selected register are kept.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                qmr_pkg::CFG_SIGNED_MODE:  cfg_next.signed_mode  = cfg_data[0];
                qmr_pkg::CFG_A_ZERO_POINT: cfg_next.a_zero_point = cfg_data[7:0];
                qmr_pkg::CFG_B_ZERO_POINT: cfg_next.b_zero_point = cfg_data[7:0];
                qmr_pkg::CFG_Y_ZERO_POINT: cfg_next.y_zero_point = cfg_data[7:0];
                qmr_pkg::CFG_SCALE_MULT:   cfg_next.scale_mult   = cfg_data[30:0];
                qmr_pkg::CFG_SCALE_SHIFT:  cfg_next.scale_shift  = cfg_data[5:0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.signed_mode  <= 1'b0;
            cfg_reg.a_zero_point <= '0;
            cfg_reg.b_zero_point <= '0;
            cfg_reg.y_zero_point <= '0;
            cfg_reg.scale_mult   <= qmr_pkg::ScaleMultReset;
            cfg_reg.scale_shift  <= qmr_pkg::ScaleShiftReset;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Stages one and two: zero-point differences and their product.
    qmr_diff u_diff (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .a_value   (s_tdata[7:0]),
        .b_value   (s_tdata[15:8]),
        .out_valid (diff_valid),
        .out_ready (diff_ready),
        .out_prod  (diff_prod)
    );

    // Stage three: multiply by the scale mantissa.
    qmr_scale u_scale (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .in_valid   (diff_valid),
        .in_ready   (diff_ready),
        .in_prod    (diff_prod),
        .out_valid  (scale_valid),
        .out_ready  (scale_ready),
        .out_scaled (scale_value)
    );

    // Stages four and five: shift and round, then zero-point add and saturate.
    qmr_round u_round (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (scale_valid),
        .in_ready  (scale_ready),
        .in_scaled (scale_value),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_value (m_tdata)
    );

    // Reset leaves the pipeline empty.
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result word valid right after reset");

    // A receiver that always takes words never holds back the input side.
    assert property (@(posedge aclk) disable iff (!aresetn) m_tready |-> s_tready)
        else $error("input stalled while the result channel is ready");

    // An empty output register always leaves room upstream.
    assert property (@(posedge aclk) disable iff (!aresetn) !m_tvalid |-> s_tready)
        else $error("input stalled while the output register is empty");

    // A stalled result word stays valid and unchanged until it is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result word changed while the receiver stalled");

endmodule

### tb/sv/tb_quantized_multiply_requantize.sv
// Self-checking testbench for the quantized multiply-requantize block.
`timescale 1ns / 1ps

module tb_quantized_multiply_requantize;

    // Number of pipeline stages, used for the pauses before register writes
    // and at the end of the run.
    localparam int PipeDepth  = 5;
    localparam int CycleLimit = 400000;
    localparam int LongHold   = 300;
    localparam int NumPhases  = 12;
    localparam int PhaseWords = 112;

    // Indexes that map to no register; writes to them must be ignored.
    localparam logic [2:0] CfgSpareLo = 3'd6;
    localparam logic [2:0] CfgSpareHi = 3'd7;

    localparam logic [qmr_pkg::MultW-1:0] MultMax = 31'h7FFF_FFFF;

    // The checker keeps its own copy of the registers, predicts the byte for
    // every accepted operand pair and compares results in order.
    class product_checker;
        qmr_pkg::cfg_t    regs;
        logic [7:0]       expected_bytes[$];
        int               failures;

        function new();
            regs.signed_mode  = 1'b0;
            regs.a_zero_point = '0;
            regs.b_zero_point = '0;
            regs.y_zero_point = '0;
            regs.scale_mult   = qmr_pkg::ScaleMultReset;
            regs.scale_shift  = qmr_pkg::ScaleShiftReset;
            failures          = 0;
        endfunction

        // Mirrors a register write; the port width already drops the high bits
        // of the index, and the data is cut to the register's own width.
        function void note_write(logic [2:0] idx, logic [30:0] data);
            case (idx)
                qmr_pkg::CFG_SIGNED_MODE:  regs.signed_mode  = data[0];
                qmr_pkg::CFG_A_ZERO_POINT: regs.a_zero_point = data[7:0];
                qmr_pkg::CFG_B_ZERO_POINT: regs.b_zero_point = data[7:0];
                qmr_pkg::CFG_Y_ZERO_POINT: regs.y_zero_point = data[7:0];
                qmr_pkg::CFG_SCALE_MULT:   regs.scale_mult   = data[30:0];
                qmr_pkg::CFG_SCALE_SHIFT:  regs.scale_shift  = data[5:0];
                default: ;
            endcase
        endfunction

        function longint level(logic [7:0] raw);
            level = (regs.signed_mode && raw[7]) ? longint'(raw) - 256 : longint'(raw);
        endfunction

        function logic [7:0] requantize(logic [7:0] a, logic [7:0] b);
            longint     da, db, scaled, total, lo, hi;
            bit [63:0]  mask, frac, half;
            da     = level(a) - level(regs.a_zero_point);
            db     = level(b) - level(regs.b_zero_point);
            scaled = da * db * longint'(regs.scale_mult);
            // Arithmetic shift floors toward minus infinity.
            total  = (scaled >>> regs.scale_shift) + level(regs.y_zero_point);
            if (regs.scale_shift != 0) begin
                mask = (64'd1 << regs.scale_shift) - 64'd1;
                frac = scaled & mask;
                half = 64'd1 << (regs.scale_shift - 1);
                if (frac > half || (frac == half && total[0]))
                    total = total + 1;
            end
            lo = regs.signed_mode ? -128 : 0;
            hi = regs.signed_mode ? 127 : 255;
            if (total < lo)
                total = lo;
            if (total > hi)
                total = hi;
            requantize = total[7:0];
        endfunction

        function void note_pair(logic [7:0] a, logic [7:0] b);
            expected_bytes.push_back(requantize(a, b));
        endfunction

        function void check_byte(logic [7:0] y);
            logic [7:0] want;
            if (expected_bytes.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("ERROR: unexpected result word y_value=%0d", y);
                return;
            end
            want = expected_bytes.pop_front();
            if (y !== want) begin
                failures++;
                if (failures <= 10)
                    $display("ERROR: y_value expected %0d, got %0d", want, y);
            end
        endfunction

        function int pending();
            pending = expected_bytes.size();
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [30:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;   // [7:0] a_value, [15:8] b_value
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;        // [7:0] y_value

    product_checker pc = new();

    // Idling controls. The sender and receiver insert random idle bursts while
    // these are set; a long hold request makes the receiver stall long enough
    // for the whole pipeline to fill and push back on the input.
    bit src_idle_on = 1'b1;
    bit sink_idle_on = 1'b1;
    bit long_hold_req = 1'b0;
    int cycles = 0;

    quantized_multiply_requantize i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #6 aclk = ~aclk;

    // A hard cycle limit guards against a hung handshake.
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CycleLimit) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Result words are taken at the rising edge, where the handshake completes.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            pc.check_byte(m_tdata);
    end

    // The receiver changes m_tready only at falling edges. Its long hold is
    // counted here, independently of the sender, which keeps offering words.
    initial begin
        int hold_left;
        int burst_left;
        hold_left  = 0;
        burst_left = 0;
        forever begin
            @(negedge aclk);
            if (long_hold_req) begin
                hold_left     = LongHold;
                long_hold_req = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (burst_left > 0) begin
                burst_left--;
                m_tready <= 1'b0;
            end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
                burst_left = $urandom_range(1, 9) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Writes one register through the configuration channel and mirrors it.
    task automatic write_reg(input logic [2:0] idx, input logic [30:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        pc.note_write(idx, data);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Offers one operand pair, possibly after a short idle burst. s_tvalid
    // stays high across back-to-back words and is lowered only for a gap.
    task automatic send_pair(input logic [7:0] a, input logic [7:0] b);
        int gap;
        if (src_idle_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 9);
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {b, a};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        pc.note_pair(a, b);
    endtask

    // Ends the stream, waits for every expected word, then lets the pipeline
    // settle so that registers can be written safely.
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pc.pending() != 0)
            @(posedge aclk);
        repeat (PipeDepth + 3) @(posedge aclk);
    endtask

    function automatic logic [7:0] pick_zero_point();
        case ($urandom_range(0, 5))
            0: pick_zero_point = 8'd0;
            1: pick_zero_point = 8'd127;
            2: pick_zero_point = 8'd128;
            3: pick_zero_point = 8'd255;
            default: pick_zero_point = 8'($urandom);
        endcase
    endfunction

    // Picks an operand: fully random, or close to its zero point so that the
    // product stays small and the rounding and saturation edges are reached.
    function automatic logic [7:0] pick_operand(logic [7:0] zp);
        if ($urandom_range(0, 3) == 0)
            pick_operand = zp + 8'($urandom_range(0, 31)) - 8'd16;
        else
            pick_operand = 8'($urandom);
    endfunction

    // Loads a fresh random setting. Zero points travel with random upper data
    // bits, which the block has to drop.
    task automatic random_setting();
        logic [qmr_pkg::MultW-1:0]  mult;
        logic [qmr_pkg::ShiftW-1:0] shift;
        case ($urandom_range(0, 3))
            0: begin
                mult  = 31'($urandom);
                shift = 6'($urandom);
            end
            1: begin
                // Scales between about 2^-17 and 1, where results rarely saturate.
                mult  = 31'($urandom_range(32'h4000_0000, 32'h7FFF_FFFF));
                shift = 6'(31 + $urandom_range(0, 16));
            end
            2: begin
                case ($urandom_range(0, 2))
                    0: mult = '0;
                    1: mult = 31'd1;
                    default: mult = MultMax;
                endcase
                case ($urandom_range(0, 3))
                    0: shift = 6'd0;
                    1: shift = 6'd1;
                    2: shift = 6'd62;
                    default: shift = 6'd63;
                endcase
            end
            default: begin
                mult  = 31'($urandom);
                shift = 6'(38 + $urandom_range(0, 20));
            end
        endcase
        write_reg(qmr_pkg::CFG_SIGNED_MODE, {30'($urandom), 1'($urandom)});
        write_reg(qmr_pkg::CFG_A_ZERO_POINT, {23'($urandom), pick_zero_point()});
        write_reg(qmr_pkg::CFG_B_ZERO_POINT, {23'($urandom), pick_zero_point()});
        write_reg(qmr_pkg::CFG_Y_ZERO_POINT, {23'($urandom), pick_zero_point()});
        write_reg(qmr_pkg::CFG_SCALE_MULT, mult);
        write_reg(qmr_pkg::CFG_SCALE_SHIFT, {25'($urandom), shift});
        if ($urandom_range(0, 3) == 0)
            write_reg($urandom_range(0, 1) ? CfgSpareLo : CfgSpareHi, 31'($urandom));
    endtask

    initial begin
        // Hold reset low at the start of the run; it is never asserted again.
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        // With the reset setting (unsigned, unity scale) the output is the plain
        // product, saturated at the top of the byte range.
        send_pair(8'd0, 8'd0);
        send_pair(8'd255, 8'd255);
        send_pair(8'd255, 8'd0);
        send_pair(8'd0, 8'd255);
        send_pair(8'd12, 8'd10);
        drain();

        // A scale of one half turns every odd product into an exact tie, so the
        // round-to-even rule decides between the two neighbors.
        write_reg(qmr_pkg::CFG_SCALE_MULT, 31'd1);
        write_reg(qmr_pkg::CFG_SCALE_SHIFT, 31'd1);
        send_pair(8'd3, 8'd1);
        send_pair(8'd5, 8'd1);
        send_pair(8'd1, 8'd1);
        send_pair(8'd7, 8'd1);
        drain();
        // Negative ties in signed mode, and a tie shifted by an odd zero point.
        write_reg(qmr_pkg::CFG_SIGNED_MODE, 31'd1);
        send_pair(8'hFF, 8'd1);
        send_pair(8'hFD, 8'd1);
        drain();
        write_reg(qmr_pkg::CFG_Y_ZERO_POINT, 31'h7FFF_FF01);
        send_pair(8'd1, 8'd1);
        drain();

        // Zero shift: no rounding at all. The zero points sit at opposite ends of
        // the signed range, giving the largest differences and saturation below.
        write_reg(qmr_pkg::CFG_SCALE_SHIFT, 31'd0);
        write_reg(qmr_pkg::CFG_A_ZERO_POINT, 31'h0000_0080);
        write_reg(qmr_pkg::CFG_B_ZERO_POINT, 31'h5555_557F);
        send_pair(8'h7F, 8'h80);
        send_pair(8'h80, 8'h7F);
        send_pair(8'h81, 8'h7E);
        drain();
        write_reg(qmr_pkg::CFG_SCALE_MULT, MultMax);
        send_pair(8'h81, 8'h7E);
        drain();

        // Zero multiplier: the result is the output zero point alone.
        write_reg(qmr_pkg::CFG_SCALE_MULT, 31'd0);
        write_reg(qmr_pkg::CFG_Y_ZERO_POINT, 31'd255);
        send_pair(8'h55, 8'hAA);
        send_pair(8'h00, 8'hFF);
        drain();

        // Largest shift, a wide value for the mode bit and writes to unused indexes.
        write_reg(qmr_pkg::CFG_SCALE_MULT, MultMax);
        write_reg(qmr_pkg::CFG_SCALE_SHIFT, 31'h7FFF_FFFF);
        write_reg(qmr_pkg::CFG_SIGNED_MODE, 31'd2);
        write_reg(CfgSpareLo, 31'h1234_5678);
        write_reg(CfgSpareHi, 31'h7FFF_FFFF);
        send_pair(8'h7F, 8'h80);
        drain();

        // Random phases, each under its own setting. One phase holds the
        // receiver off for a long stretch; the last two run without idling.
        for (int phase = 0; phase < NumPhases; phase++) begin
            random_setting();
            if (phase >= NumPhases - 2) begin
                src_idle_on  = 1'b0;
                sink_idle_on = 1'b0;
            end
            if (phase == 3)
                long_hold_req = 1'b1;
            for (int n = 0; n < PhaseWords; n++)
                send_pair(pick_operand(pc.regs.a_zero_point),
                          pick_operand(pc.regs.b_zero_point));
            drain();
        end

        if (pc.failures == 0 && pc.pending() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
